[design/sfc_pkg.sv]
package sfc_pkg;

  // Fixed field widths.
  localparam int WORD_W      = 32;
  localparam int CLIP_W      = 31;
  localparam int RAD_W       = 31;
  localparam int IDX_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int TABLE_WORDS = 20;

  localparam int DEF_FRAC_BITS = 16;

  // Default clip distances: near is one tenth, far is three hundred units.
  localparam int NEAR_DEF_DIV  = 10;
  localparam int FAR_DEF_UNITS = 300;

  // Item opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR  = 2'd1;

  // Table slot layout.
  localparam int SLOT_MX     = 0;
  localparam int SLOT_MY     = 4;
  localparam int SLOT_MZ     = 8;
  localparam int SLOT_LEFT   = 12;
  localparam int SLOT_RIGHT  = 14;
  localparam int SLOT_TOP    = 16;
  localparam int SLOT_BOTTOM = 18;
  localparam int ROW_STRIDE  = 4;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Travels alongside each test item through the pipeline.
  typedef struct packed {
    logic             valid;
    logic [RAD_W-1:0] radius;
  } tag_t;

  // Side-plane coefficients captured for one test item.
  typedef struct packed {
    word_t la;
    word_t lc;
    word_t ra;
    word_t rc;
    word_t tb;
    word_t tc;
    word_t bb;
    word_t bc;
  } planes_t;

endpackage

[design/sphere_frustum_cull.sv]
// A test beat passes through the input register, the transform and the plane
// test before its result is strobed on done. Throughput: one beat per cycle,
// load or test, with busy never raised. The receiver cannot stall: every result
// is shown for exactly one cycle. Reset (rst, synchronous) empties the pipeline
// and restores the clip registers; the coefficient table is undefined until loaded.
module sphere_frustum_cull #(
  parameter int FRAC_BITS = sfc_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [sfc_pkg::IDX_W-1:0]     coef_index,
  input  sfc_pkg::word_t                coef_value,
  input  sfc_pkg::word_t                center_x,
  input  sfc_pkg::word_t                center_y,
  input  sfc_pkg::word_t                center_z,
  input  logic [sfc_pkg::RAD_W-1:0]     sphere_radius,
  output logic                          done,
  output logic                          visible,
  output sfc_pkg::word_t                view_depth,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfc_pkg::CLIP_W-1:0]    cfg_data
);
  import sfc_pkg::*;

  // Reset clip distances follow the fraction width. The far default is
  // clamped to the largest value the register can hold.
  localparam longint ONE_FIX   = longint'(1) << FRAC_BITS;
  localparam longint CLIP_MAX  = (longint'(1) << CLIP_W) - 1;
  localparam longint FAR_FULL  = longint'(FAR_DEF_UNITS) << FRAC_BITS;
  localparam logic [CLIP_W-1:0] NEAR_RESET =
    CLIP_W'((ONE_FIX + NEAR_DEF_DIV / 2) / NEAR_DEF_DIV);
  localparam logic [CLIP_W-1:0] FAR_RESET =
    CLIP_W'((FAR_FULL > CLIP_MAX) ? CLIP_MAX : FAR_FULL);

  logic              accept;
  logic              table_we;
  logic [CLIP_W-1:0] near_clip;
  logic [CLIP_W-1:0] far_clip;
  tag_t              tag0;
  word_t             centre0 [3];
  word_t             coefs [TABLE_WORDS];
  tag_t              tag2;
  word_t             view2 [3];
  planes_t           planes2;

  // Every stage moves on each cycle, so the block never holds a beat off.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // A load beat writes the table at its accepting edge. Any test accepted
  // earlier takes its coefficients into stage 1 no later than that edge, and
  // any test accepted later sees the new word, so order is preserved.
  assign table_we = accept && (opcode == OP_LOAD);

  // Clip registers. Writes to indexes past the far clip are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      near_clip <= NEAR_RESET;
      far_clip  <= FAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_NEAR) begin
        near_clip <= cfg_data;
      end else if (cfg_index == REG_FAR) begin
        far_clip <= cfg_data;
      end
    end
  end

  // Stage 0: the input register. Only test beats enter the pipeline.
  always_ff @(posedge clk) begin
    centre0[0]  <= center_x;
    centre0[1]  <= center_y;
    centre0[2]  <= center_z;
    tag0.radius <= sphere_radius;
    if (rst) begin
      tag0.valid <= 1'b0;
    end else begin
      tag0.valid <= accept && (opcode == OP_TEST);
    end
  end

  sfc_coef_table u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (table_we),
    .idx   (coef_index),
    .value (coef_value),
    .words (coefs)
  );

  // Stages 1 and 2: world-to-view transform of the centre.
  sfc_transform #(
    .FRAC_BITS (FRAC_BITS)
  ) u_transform (
    .clk        (clk),
    .rst        (rst),
    .tag_in     (tag0),
    .centre     (centre0),
    .coefs      (coefs),
    .tag_out    (tag2),
    .view       (view2),
    .planes_out (planes2)
  );

  // Stages 3 and 4: near, far and side-plane rejection, then the result.
  sfc_plane_test #(
    .FRAC_BITS (FRAC_BITS)
  ) u_plane_test (
    .clk        (clk),
    .rst        (rst),
    .tag_in     (tag2),
    .view       (view2),
    .planes     (planes2),
    .near_clip  (near_clip),
    .far_clip   (far_clip),
    .done       (done),
    .visible    (visible),
    .view_depth (view_depth)
  );

  // Each result beat must trace back to an accepted test beat.
  a_result_from_test: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (opcode == OP_TEST), 5))
    else $error("result strobe without a matching test beat");

endmodule

[design/sfc_coef_table.sv]
module sfc_coef_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [sfc_pkg::IDX_W-1:0] idx,
  input  sfc_pkg::word_t            value,
  output sfc_pkg::word_t            words [sfc_pkg::TABLE_WORDS]
);
  import sfc_pkg::*;

  // Slots beyond the table are silently dropped.
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_WORDS; i++) begin
      if (we && (idx == IDX_W'(i))) begin
        words[i] <= value;
      end
    end
  end

  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    (we && (idx < IDX_W'(TABLE_WORDS))) |=> (words[$past(idx)] == $past(value)))
    else $error("coefficient write did not land");

endmodule

[design/sfc_transform.sv]
module sfc_transform #(
  parameter int FRAC_BITS = sfc_pkg::DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  sfc_pkg::tag_t     tag_in,
  input  sfc_pkg::word_t    centre [3],
  input  sfc_pkg::word_t    coefs [sfc_pkg::TABLE_WORDS],
  output sfc_pkg::tag_t     tag_out,
  output sfc_pkg::word_t    view [3],
  output sfc_pkg::planes_t  planes_out
);
  import sfc_pkg::*;

  localparam int SUM_W = PROD_W + 2;

  tag_t             tag1;
  prod_t            prod [3][3];
  word_t            bias [3];
  planes_t          planes1;
  logic signed [SUM_W-1:0] row_sum [3];
  word_t            view_next [3];

  function automatic word_t sat_word(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-WORD_W:0] hi;
    hi = v[SUM_W-1:WORD_W-1];
    if ((&hi) || !(|hi)) begin
      return v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

  // Stage 1: nine products, translation terms and plane terms captured.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] <= PROD_W'(coefs[r * ROW_STRIDE + k]) * PROD_W'(centre[k]);
      end
      bias[r] <= coefs[r * ROW_STRIDE + 3];
    end
    planes1.la  <= coefs[SLOT_LEFT];
    planes1.lc  <= coefs[SLOT_LEFT + 1];
    planes1.ra  <= coefs[SLOT_RIGHT];
    planes1.rc  <= coefs[SLOT_RIGHT + 1];
    planes1.tb  <= coefs[SLOT_TOP];
    planes1.tc  <= coefs[SLOT_TOP + 1];
    planes1.bb  <= coefs[SLOT_BOTTOM];
    planes1.bc  <= coefs[SLOT_BOTTOM + 1];
    tag1.radius <= tag_in.radius;
    if (rst) begin
      tag1.valid <= 1'b0;
    end else begin
      tag1.valid <= tag_in.valid;
    end
  end

  // Stage 2: exact row sums, floor shift and saturation.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2])
                 + (SUM_W'(bias[r]) <<< FRAC_BITS);
      view_next[r] = sat_word(row_sum[r] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    view           <= view_next;
    planes_out     <= planes1;
    tag_out.radius <= tag1.radius;
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag1.valid;
    end
  end

endmodule

[design/sfc_plane_test.sv]
module sfc_plane_test #(
  parameter int FRAC_BITS = sfc_pkg::DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sfc_pkg::tag_t              tag_in,
  input  sfc_pkg::word_t             view [3],
  input  sfc_pkg::planes_t           planes,
  input  logic [sfc_pkg::CLIP_W-1:0] near_clip,
  input  logic [sfc_pkg::CLIP_W-1:0] far_clip,
  output logic                       done,
  output logic                       visible,
  output sfc_pkg::word_t             view_depth
);
  import sfc_pkg::*;

  localparam int EXT_W  = WORD_W + 2;
  localparam int DIST_W = PROD_W + 1;

  tag_t  tag3;
  prod_t pp [8];
  word_t depth3;
  logic  depth_ok3;
  logic  depth_ok_next;
  logic signed [EXT_W-1:0]  rad_ext;
  logic signed [DIST_W-1:0] plane_dist [4];
  logic signed [DIST_W-1:0] limit;
  logic [3:0]               beyond;

  // Near and far tests on the saturated depth, widened so nothing wraps.
  always_comb begin
    rad_ext       = $signed(EXT_W'(tag_in.radius));
    depth_ok_next = ((EXT_W'(view[2]) + rad_ext) >= $signed(EXT_W'(near_clip)))
                 && ((EXT_W'(view[2]) - rad_ext) <= $signed(EXT_W'(far_clip)));
  end

  // Stage 3: the eight plane products.
  always_ff @(posedge clk) begin
    pp[0]       <= PROD_W'(view[0]) * PROD_W'(planes.la);
    pp[1]       <= PROD_W'(view[2]) * PROD_W'(planes.lc);
    pp[2]       <= PROD_W'(view[0]) * PROD_W'(planes.ra);
    pp[3]       <= PROD_W'(view[2]) * PROD_W'(planes.rc);
    pp[4]       <= PROD_W'(view[1]) * PROD_W'(planes.tb);
    pp[5]       <= PROD_W'(view[2]) * PROD_W'(planes.tc);
    pp[6]       <= PROD_W'(view[1]) * PROD_W'(planes.bb);
    pp[7]       <= PROD_W'(view[2]) * PROD_W'(planes.bc);
    depth3      <= view[2];
    depth_ok3   <= depth_ok_next;
    tag3.radius <= tag_in.radius;
    if (rst) begin
      tag3.valid <= 1'b0;
    end else begin
      tag3.valid <= tag_in.valid;
    end
  end

  // Stage 4: the sphere is outside a plane when the exact distance, still
  // carrying its fraction bits, exceeds the radius at the same scale.
  always_comb begin
    limit = $signed(DIST_W'(tag3.radius)) <<< FRAC_BITS;
    for (int i = 0; i < 4; i++) begin
      plane_dist[i] = DIST_W'(pp[2 * i]) + DIST_W'(pp[2 * i + 1]);
      beyond[i]     = plane_dist[i] > limit;
    end
  end

  always_ff @(posedge clk) begin
    visible    <= depth_ok3 && !(|beyond);
    view_depth <= depth3;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag3.valid;
    end
  end

  a_depth_carried: assert property (@(posedge clk) disable iff (rst)
    done |-> (view_depth == $past(view[2], 2)))
    else $error("reported depth does not match the transformed depth");

endmodule
